/* rtl/core/spq_pkg.sv */
`default_nettype none
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 8;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// One stored slot of the sorted chain.
	typedef struct packed {
		logic                     valid;
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	// Operation broadcast to every cell in the cycle a request is accepted.
	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} op_t;

endpackage
`default_nettype wire

/* rtl/core/spq_cell.sv */
`default_nettype none
module spq_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spq_pkg::op_t   op,
	input  wire spq_pkg::entry_t prev_entry,
	input  wire logic           prev_past,
	input  wire spq_pkg::entry_t next_entry,
	output spq_pkg::entry_t     entry,
	output logic                past
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	// A cell lies past the insertion point when it is free or holds a strictly
	// larger priority; the sorted prefix makes this flag monotonic along the chain.
	assign past  = !entry_q.valid || (entry_q.prio > op.prio);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		priority if (op.deq) begin
			entry_d = next_entry;
		end else if (op.enq && past) begin
			if (prev_past) begin
				entry_d = prev_entry;
			end else begin
				entry_d.valid = 1'b1;
				entry_d.prio  = op.prio;
				entry_d.data  = op.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sorted_priority_queue_top.sv */
`default_nettype none
// Sorted priority queue built as a chain of CAPACITY cells, head in cell 0.
// On each accepted request every cell compares its priority with
// the request at once and either holds, takes the new entry, or takes its
// neighbor's entry, so a request can be accepted in every cycle while the
// result register is free or being drained. Enqueue places the entry after all
// entries of equal or smaller priority; dequeue returns the head. Enqueue into
// a full queue reports full and drops the entry, dequeue of an empty queue
// reports empty; in both cases and on enqueue the returned data and priority
// are zero. Exactly one result follows each request.
module sorted_priority_queue_top #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               cmd,
	input  wire logic signed [31:0] item_data,
	input  wire logic [7:0]         item_priority,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      out_data,
	output logic [7:0]              out_priority
);

	spq_pkg::entry_t cell_entry [CAPACITY];
	logic            cell_past  [CAPACITY];
	spq_pkg::op_t    op;

	logic            accept;
	logic            full;
	logic            empty;
	spq_pkg::status_t status_d;

	logic             out_valid_q;
	spq_pkg::status_t status_q;
	logic signed [31:0] out_data_q;
	logic [7:0]       out_priority_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = cell_entry[CAPACITY-1].valid;
	assign empty    = !cell_entry[0].valid;

	always_comb begin
		op.enq  = accept && (cmd == spq_pkg::CMD_ENQ) && !full;
		op.deq  = accept && (cmd == spq_pkg::CMD_DEQ) && !empty;
		op.prio = item_priority;
		op.data = item_data;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t prev_e;
		logic            prev_p;
		spq_pkg::entry_t next_e;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_p = 1'b0;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_p = cell_past[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_link
			assign next_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.prev_entry (prev_e),
			.prev_past  (prev_p),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.past       (cell_past[i])
		);
	end

	always_comb begin
		if (cmd == spq_pkg::CMD_ENQ) begin
			status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
		end else begin
			status_d = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DEQUEUED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			if (op.deq) begin
				out_data_q     <= cell_entry[0].data;
				out_priority_q <= cell_entry[0].prio;
			end else begin
				out_data_q     <= '0;
				out_priority_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_priority_q;

endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		spq_pkg::status_t                  st;
		logic signed [spq_pkg::DATA_W-1:0] data;
		logic [spq_pkg::PRIO_W-1:0]        prio;
	} reply_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     cmd;
	logic signed [31:0]       item_data;
	logic [7:0]               item_priority;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               status;
	logic signed [31:0]       out_data;
	logic [7:0]               out_priority;

	// Shadow copy of the sorted store, head at index 0.
	logic signed [spq_pkg::DATA_W-1:0] held_data [QUEUE_DEPTH];
	logic [spq_pkg::PRIO_W-1:0]        held_prio [QUEUE_DEPTH];
	int                       held_count;

	reply_t                   awaited_replies [$];
	reply_t                   head_reply;
	int                       failures;
	int                       planned_fill;
	bit                       gaps_on;
	int                       stall_left;

	sorted_priority_queue_top #(
		.CAPACITY(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.item_data(item_data),
		.item_priority(item_priority),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_data(out_data),
		.out_priority(out_priority)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int pick;
		if (!gaps_on)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic apply_request(input logic op,
			input logic signed [spq_pkg::DATA_W-1:0] word,
			input logic [spq_pkg::PRIO_W-1:0] prio);
		reply_t r;
		int pos;
		r.st = spq_pkg::ST_ENQUEUED;
		r.data = '0;
		r.prio = '0;
		if (op == spq_pkg::CMD_ENQ) begin
			if (held_count == QUEUE_DEPTH) begin
				r.st = spq_pkg::ST_FULL;
			end else begin
				// A new entry goes behind every entry of equal or smaller priority.
				pos = 0;
				while (pos < held_count && held_prio[pos] <= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_data[i] = held_data[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_data[pos] = word;
				held_prio[pos] = prio;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.st = spq_pkg::ST_EMPTY;
		end else begin
			r.st = spq_pkg::ST_DEQUEUED;
			r.data = held_data[0];
			r.prio = held_prio[0];
			for (int i = 0; i < held_count - 1; i++) begin
				held_data[i] = held_data[i+1];
				held_prio[i] = held_prio[i+1];
			end
			held_count--;
		end
		awaited_replies.push_back(r);
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready)
			apply_request(cmd, item_data, item_priority);
		if (out_valid && out_ready) begin
			if (awaited_replies.size() == 0) begin
				$error("reply with no request outstanding: status %0d", status);
				failures++;
			end else begin
				head_reply = awaited_replies.pop_front();
				if (status !== head_reply.st) begin
					$error("status: expected %s, got %0d", head_reply.st.name(), status);
					failures++;
				end
				if (out_data !== head_reply.data) begin
					$error("out_data: expected %0d, got %0d", head_reply.data, out_data);
					failures++;
				end
				if (out_priority !== head_reply.prio) begin
					$error("out_priority: expected %0d, got %0d", head_reply.prio,
						out_priority);
					failures++;
				end
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	task automatic send_request(input logic op, input logic signed [31:0] word,
			input logic [7:0] prio);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		item_data <= word;
		item_priority <= prio;
		do @(posedge clk); while (!in_ready);
		if (op == spq_pkg::CMD_ENQ && planned_fill < QUEUE_DEPTH)
			planned_fill++;
		else if (op == spq_pkg::CMD_DEQ && planned_fill > 0)
			planned_fill--;
	endtask

	task automatic test_dequeue_empty();
		send_request(spq_pkg::CMD_DEQ, 32'sh7fffffff, 8'hff);
		send_request(spq_pkg::CMD_DEQ, 32'sh80000000, 8'h00);
	endtask

	task automatic test_fill_and_overflow();
		logic [7:0] prios [QUEUE_DEPTH];
		logic signed [31:0] words [QUEUE_DEPTH];
		prios = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd7, 8'd1, 8'd254,
			8'd128, 8'd0, 8'd64, 8'd3, 8'd255, 8'd2, 8'd0, 8'd200};
		words = '{32'sh80000000, 32'sh7fffffff, 32'sh00000000, 32'shffffffff,
			32'sh55555555, 32'shaaaaaaaa, 32'sh00000001, 32'sh80000001,
			32'sh7ffffffe, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh12345678,
			32'sh87654321, 32'sh00ff00ff, 32'shff00ff00, 32'sh3c3c3c3c};
		foreach (prios[i])
			send_request(spq_pkg::CMD_ENQ, words[i], prios[i]);
		// The store is full now, so both of these must be dropped.
		send_request(spq_pkg::CMD_ENQ, 32'sh7fffffff, 8'd0);
		send_request(spq_pkg::CMD_ENQ, 32'sh80000000, 8'd255);
	endtask

	task automatic test_drain_head();
		repeat (4)
			send_request(spq_pkg::CMD_DEQ, $urandom, 8'($urandom_range(0, 255)));
		// With the held zeros drained, a new priority-zero entry goes straight to the head.
		send_request(spq_pkg::CMD_ENQ, 32'sh0badcafe, 8'd0);
		send_request(spq_pkg::CMD_DEQ, 32'sh0, 8'd0);
		send_request(spq_pkg::CMD_DEQ, 32'sh0, 8'd0);
	endtask

	task automatic run_traffic(input int n_items, input int prio_top);
		int goal;
		int stretch;
		int sent;
		int pick;
		logic op;
		logic [7:0] prio;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 3);
			goal = (pick == 0) ? 0 :
				(pick == 1) ? QUEUE_DEPTH : $urandom_range(1, QUEUE_DEPTH - 1);
			stretch = $urandom_range(4, 40);
			repeat (stretch) begin
				pick = $urandom_range(0, 9);
				if (planned_fill < goal)
					op = (pick < 8) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
				else if (planned_fill > goal)
					op = (pick < 8) ? spq_pkg::CMD_DEQ : spq_pkg::CMD_ENQ;
				else
					op = (pick < 5) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
				if (prio_top == 255) begin
					pick = $urandom_range(0, 9);
					prio = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
				end else begin
					prio = 8'($urandom_range(0, prio_top));
				end
				send_request(op, $urandom, prio);
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(700, 255);
	endtask

	task automatic test_priority_ties();
		run_traffic(300, 3);
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		run_traffic(300, 15);
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = spq_pkg::CMD_ENQ;
		item_data = '0;
		item_priority = '0;
		failures = 0;
		held_count = 0;
		planned_fill = 0;
		gaps_on = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_dequeue_empty();
		test_fill_and_overflow();
		test_drain_head();
		test_random_traffic();
		test_priority_ties();
		test_back_to_back();

		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
bench/tb.sv
